FILE: rtl/atm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atm_pkg
// Shared types, constants and helpers for the 3x3 alpha-trimmed mean filter.
// ----------------------------------------------------------------------------
package atm_pkg;

  localparam int PIX_W   = 8;   // sample width
  localparam int LINE_W  = 11;  // line_width register width
  localparam int TRIM_W  = 4;   // trim_level register width
  localparam int SUM_W   = 12;  // holds 9 * 255
  localparam int COL_W   = 3 * PIX_W;
  localparam int WIN_N   = 9;
  localparam int CFG_W   = LINE_W;

  localparam logic [TRIM_W-1:0] TRIM_MAX = 4'd8;

  // register indexes on the configuration port
  localparam logic REG_LINE_WIDTH = 1'b0;
  localparam logic REG_TRIM_LEVEL = 1'b1;

  // three window columns, each packed top | mid << 8 | bottom << 16
  typedef struct packed {
    logic [COL_W-1:0] c2;
    logic [COL_W-1:0] c1;
    logic [COL_W-1:0] c0;
  } win_t;

  // first sorted position kept
  function automatic logic [TRIM_W-1:0] trim_lo(input logic [TRIM_W-1:0] a);
    return (a + 4'd1) >> 1;
  endfunction

  // one past the last sorted position kept
  function automatic logic [TRIM_W-1:0] trim_hi(input logic [TRIM_W-1:0] a);
    logic [TRIM_W:0] t;
    t = ({a, 1'b0} + 5'd1) >> 2;
    return 4'd9 - t[TRIM_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/atm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atm_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module atm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                                  clk,
  input  wire logic                                  wen,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  ren,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/atm_tmean.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atm_tmean
// Trimmed mean of one 3x3 window: iterative odd-even transposition sort,
// masked sum, then an 8-step restoring divide by 9 - a.
// ----------------------------------------------------------------------------
module atm_tmean
  import atm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire win_t              win,
  input  wire logic [TRIM_W-1:0] trim,
  output logic                   done,
  output logic [PIX_W-1:0]       result
);

  typedef enum logic [3:0] {
    T_IDLE = 4'b0001,
    T_SORT = 4'b0010,
    T_SUM  = 4'b0100,
    T_DIV  = 4'b1000
  } tstate_t;

  tstate_t            state;
  logic [PIX_W-1:0]   v [WIN_N];
  logic [PIX_W-1:0]   v_next [WIN_N];
  logic [3:0]         step;
  logic [TRIM_W-1:0]  a;
  logic [SUM_W-1:0]   rem;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   dsh;
  logic [TRIM_W-1:0]  lo;
  logic [TRIM_W-1:0]  hi;

  // one round of the transposition sort; parity follows the round count
  always_comb begin
    for (int k = 0; k < WIN_N; k++) begin
      v_next[k] = v[k];
    end
    for (int k = 0; k < WIN_N - 1; k++) begin
      if ((k[0] == step[0]) && (v[k] > v[k+1])) begin
        v_next[k]   = v[k+1];
        v_next[k+1] = v[k];
      end
    end
  end

  assign lo = trim_lo(a);
  assign hi = trim_hi(a);

  always_comb begin
    sum = '0;
    for (int i = 0; i < WIN_N; i++) begin
      if ((4'(i) >= lo) && (4'(i) < hi)) begin
        sum = sum + {{(SUM_W-PIX_W){1'b0}}, v[i]};
      end
    end
  end

  assign dsh = {{(SUM_W-TRIM_W){1'b0}}, 4'd9 - a} << step[2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        T_IDLE: begin
          if (start) begin
            for (int j = 0; j < 3; j++) begin
              v[j]     <= win.c0[j*PIX_W +: PIX_W];
              v[j + 3] <= win.c1[j*PIX_W +: PIX_W];
              v[j + 6] <= win.c2[j*PIX_W +: PIX_W];
            end
            a     <= (trim > TRIM_MAX) ? TRIM_MAX : trim;
            step  <= '0;
            state <= T_SORT;
          end
        end
        T_SORT: begin
          for (int k = 0; k < WIN_N; k++) begin
            v[k] <= v_next[k];
          end
          step <= step + 4'd1;
          if (step == 4'(WIN_N - 1)) begin
            state <= T_SUM;
          end
        end
        T_SUM: begin
          rem    <= sum;
          result <= '0;
          step   <= 4'd7;
          state  <= T_DIV;
        end
        T_DIV: begin
          if (rem >= dsh) begin
            rem    <= rem - dsh;
            result <= {result[PIX_W-2:0], 1'b1};
          end else begin
            result <= {result[PIX_W-2:0], 1'b0};
          end
          if (step == 4'd0) begin
            done  <= 1'b1;
            state <= T_IDLE;
          end else begin
            step <= step - 4'd1;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/alpha_trimmed_mean_3x3_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alpha_trimmed_mean_3x3_top
// Streaming 3x3 alpha-trimmed mean filter for one 8-bit channel.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one transaction each; after the last row the
// host sends one drain transaction (mode = 1) per column, standing for the
// replicated bottom row. Edges are replicated, each result lags its input by
// one row and one column, and the last column of a row yields two results.
// The two previous rows live in one RAM of LINE_MAX x 16 bits (upper and
// middle sample side by side), read when an item is accepted and written
// back in the cycle after, so the next item always sees the update. Each
// result passes through the single shared trimmed-mean unit (9 sort rounds,
// a sum step, 8 divide steps), then a state that sees its done flag and one
// that hands it over to the output register. No new item is taken while a
// mean is in progress, but results sit in an output register, so a new item
// is taken while one still waits downstream.
// There is no clearing pass: the line RAM needs none, as each row is written
// before it is read. Configuration (line_width, trim_level) is to be written only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module alpha_trimmed_mean_3x3_top
  import atm_pkg::*;
#(
  parameter int LINE_MAX = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration
  input  wire logic              cfg_wen,
  input  wire logic              cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              mode,
  input  wire logic [PIX_W-1:0]  pixel,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [PIX_W-1:0]       filtered,
  output logic                   row_last,
  output logic                   frame_last
);

  localparam int CW   = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
  localparam int CMPW = (CW + 1 > LINE_W) ? CW + 1 : LINE_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,  // ready for a transaction, line RAM read issued
    S_LOAD = 6'b000010,  // RAM data in hand: update state, launch first mean
    S_RUN1 = 6'b000100,  // mean of previous column in progress
    S_PUT1 = 6'b001000,  // hand it to the output register
    S_RUN2 = 6'b010000,  // mean of the last column in progress
    S_PUT2 = 6'b100000
  } state_t;

  state_t             state, state_next;

  // configuration registers
  logic [LINE_W-1:0]  line_width;
  logic [TRIM_W-1:0]  trim_level;

  // stream position
  logic [CW-1:0]      column_count, column_count_next;
  logic               rows_seen, rows_seen_next;

  // previous two window columns
  logic [COL_W-1:0]   win_lo, win_lo_next;
  logic [COL_W-1:0]   win_hi, win_hi_next;

  // captured transaction and job flags
  logic               in_mode_q;
  logic [PIX_W-1:0]   in_pix_q;
  logic               job_last, job_last_next;
  logic               job_mode, job_mode_next;

  // line RAM
  logic [2*PIX_W-1:0] ram_rdata;
  logic               ram_wen;
  logic [2*PIX_W-1:0] ram_wdata;
  logic               in_fire;

  // trimmed-mean unit
  logic               tm_start;
  win_t               tm_win;
  logic               tm_done;
  logic [PIX_W-1:0]   tm_result;

  // output register
  logic               out_load;
  logic               out_rl, out_fl;

  logic [PIX_W-1:0]   top_s, mid_s, bot_s;
  logic [COL_W-1:0]   col;
  logic [CW:0]        c_plus1;
  logic               last;
  logic               col_zero;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // last column: count reached width-1 (a width of 0 acts as 1, a width
  // above LINE_MAX saturates at the end of the RAM)
  assign c_plus1  = {1'b0, column_count} + {{CW{1'b0}}, 1'b1};
  assign last     = (line_width == '0)
                 || (CMPW'(c_plus1) >= CMPW'(line_width))
                 || (column_count == CW'(LINE_MAX - 1));
  assign col_zero = (column_count == '0);

  // RAM word: upper sample low, middle sample high
  assign top_s = ram_rdata[PIX_W-1:0];
  assign mid_s = ram_rdata[2*PIX_W-1:PIX_W];
  assign bot_s = in_mode_q ? mid_s : in_pix_q;
  assign col   = {bot_s, mid_s, top_s};

  // rows shift down on every real pixel; the very first row seeds both
  assign ram_wdata = {in_pix_q, rows_seen ? mid_s : in_pix_q};

  atm_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (LINE_MAX)
  ) u_line_ram (
    .clk   (clk),
    .wen   (ram_wen),
    .waddr (column_count),
    .wdata (ram_wdata),
    .ren   (in_fire),
    .raddr (column_count),
    .rdata (ram_rdata)
  );

  atm_tmean u_tmean (
    .clk    (clk),
    .rst    (rst),
    .start  (tm_start),
    .win    (tm_win),
    .trim   (trim_level),
    .done   (tm_done),
    .result (tm_result)
  );

  always_comb begin
    state_next        = state;
    column_count_next = column_count;
    rows_seen_next    = rows_seen;
    win_lo_next       = win_lo;
    win_hi_next       = win_hi;
    job_last_next     = job_last;
    job_mode_next     = job_mode;
    ram_wen           = 1'b0;
    tm_start          = 1'b0;
    tm_win            = '{c2: col, c1: win_hi, c0: win_lo};
    out_load          = 1'b0;
    out_rl            = 1'b0;
    out_fl            = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        state_next = S_IDLE;
        // a drain before any row is dropped without trace
        if (!(in_mode_q && !rows_seen)) begin
          ram_wen           = !in_mode_q;
          column_count_next = last ? '0 : c_plus1[CW-1:0];
          if (last) begin
            rows_seen_next = !in_mode_q;
          end
          job_last_next = last;
          job_mode_next = in_mode_q;
          if (rows_seen) begin
            // left edge replicates the current column
            win_lo_next = col_zero ? col : win_hi;
            win_hi_next = col;
            if (!col_zero) begin
              tm_start   = 1'b1;
              state_next = S_RUN1;
            end else if (last) begin
              tm_start   = 1'b1;
              tm_win     = '{c2: col, c1: col, c0: col};
              state_next = S_RUN2;
            end
          end
        end
      end
      S_RUN1: begin
        if (tm_done) begin
          state_next = S_PUT1;
        end
      end
      S_PUT1: begin
        if (!out_valid || out_ready) begin
          out_load = 1'b1;
          if (job_last) begin
            // right edge replicates the last column
            tm_start   = 1'b1;
            tm_win     = '{c2: win_hi, c1: win_hi, c0: win_lo};
            state_next = S_RUN2;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_RUN2: begin
        if (tm_done) begin
          state_next = S_PUT2;
        end
      end
      S_PUT2: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          out_rl     = 1'b1;
          out_fl     = job_mode;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      line_width   <= 11'd1024;
      trim_level   <= '0;
      column_count <= '0;
      rows_seen    <= 1'b0;
      win_lo       <= '0;
      win_hi       <= '0;
      job_last     <= 1'b0;
      job_mode     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      column_count <= column_count_next;
      rows_seen    <= rows_seen_next;
      win_lo       <= win_lo_next;
      win_hi       <= win_hi_next;
      job_last     <= job_last_next;
      job_mode     <= job_mode_next;
      if (cfg_wen) begin
        case (cfg_index)
          REG_LINE_WIDTH: line_width <= cfg_data;
          REG_TRIM_LEVEL: trim_level <= cfg_data[TRIM_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_mode_q <= mode;
      in_pix_q  <= pixel;
    end
    if (out_load) begin
      filtered   <= tm_result;
      row_last   <= out_rl;
      frame_last <= out_fl;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/atm_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atm_check
// Port-level checks for the 3x3 alpha-trimmed mean filter.
// ----------------------------------------------------------------------------
module atm_check
  import atm_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [PIX_W-1:0] filtered,
  input wire logic             row_last,
  input wire logic             frame_last
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(filtered))
    else $error("stalled result dropped or changed");

  // the frame ends only on the last pixel of a row
  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> row_last)
    else $error("frame_last without row_last");

  // one transaction at a time: busy right after a transaction is taken
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken back to back");

  // reset leaves no result pending
  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind alpha_trimmed_mean_3x3_top atm_check u_atm_check (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .filtered   (filtered),
  .row_last   (row_last),
  .frame_last (frame_last)
);
`default_nettype wire

FILE: verif/alpha_trimmed_mean_3x3_top_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alpha_trimmed_mean_3x3_top_tb
// Self-checking bench for the streaming 3x3 alpha-trimmed mean filter.
// ----------------------------------------------------------------------------
// A scripted opening covers an ignored drain tick, a flat frame at full scale,
// a mixed frame at the heaviest trim and a one-pixel-wide line (register
// value 0). A line width shrunk in the middle of a row follows. The bulk is
// random frames of random content with varying width and trim, a few broken
// frames, one stretch with the width register at all ones (clamped to the
// line store) and one long receiver hold-off. Every result is checked
// against a behavioural model of the window, the sort and the truncating
// divide held in this bench.
// ----------------------------------------------------------------------------
module alpha_trimmed_mean_3x3_top_tb;
  import atm_pkg::*;

  localparam int LINE_MAX      = 1024;
  localparam int RAND_ITEMS    = 500;     // random transactions to aim for
  localparam int QUIET_ITEMS   = 60;      // closing stretch with no idling at all
  localparam int HOLD_AT       = 150;     // random transaction that triggers the hold-off
  localparam int HOLD_CYCLES   = 600;     // long enough to back the block up
  localparam int BIG_PHASE     = 2;       // phase that runs at an all-ones width
  localparam int BIG_PIXELS    = 20;      // pixels sent before the width is pulled in
  localparam int SETTLE_CYCLES = 48;      // > one result through sort, sum and divide
  localparam int DRAIN_LIMIT   = 20000;
  localparam int TIMEOUT_NS    = 10_000_000;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  typedef enum logic {ROW_CFG, ROW_ITEM} script_kind_t;

  // one line of the opening script: a register write or a transaction
  typedef struct packed {
    script_kind_t     kind;
    logic             idx;
    logic [CFG_W-1:0] val;
    logic             md;
    logic [PIX_W-1:0] px;
    logic             pinned;   // result value known by inspection
    logic [PIX_W-1:0] pin_val;
  } script_row_t;

  typedef struct packed {
    logic [PIX_W-1:0] filtered;
    logic             row_last;
    logic             frame_last;
  } px_result_t;

  // --------------------------------------------------------------------------
  // Block under test and its stimulus
  // --------------------------------------------------------------------------
  logic             clk        = 1'b0;
  logic             rst        = 1'b1;
  logic             cfg_wen    = 1'b0;
  logic             cfg_index  = 1'b0;
  logic [CFG_W-1:0] cfg_data   = '0;
  logic             in_valid   = 1'b0;
  logic             mode       = 1'b0;
  logic [PIX_W-1:0] pixel      = '0;
  logic             out_ready  = 1'b0;
  logic             in_ready;
  logic             out_valid;
  logic [PIX_W-1:0] filtered;
  logic             row_last;
  logic             frame_last;

  alpha_trimmed_mean_3x3_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .pixel      (pixel),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .filtered   (filtered),
    .row_last   (row_last),
    .frame_last (frame_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Filter model: line stores, last two window columns, position in the frame
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] upper_q  [LINE_MAX];
  logic [PIX_W-1:0] middle_q [LINE_MAX];
  logic [COL_W-1:0] win_older  = '0;
  logic [COL_W-1:0] win_newer  = '0;
  int               col_pos    = 0;
  logic             rows_seen  = 1'b0;   // first row of the frame is complete
  logic [CFG_W-1:0] width_reg  = CFG_W'(1024);
  logic [TRIM_W-1:0] trim_reg  = '0;

  px_result_t expected_px [$];

  // bookkeeping shared by the processes
  int   errors         = 0;
  int   items_sent     = 0;
  int   ignored_drains = 0;
  int   rand_items     = 0;
  int   results_seen   = 0;
  int   frames_seen    = 0;
  int   tx_idle_pct    = 0;   // chance per transaction of a sender gap
  int   rx_idle_pct    = 0;   // chance per cycle of a receiver stall burst
  bit   counting       = 1'b0;
  bit   quiet          = 1'b0;
  bit   hold_req       = 1'b0;
  bit   hold_done      = 1'b0;

  // effective line length: 0 behaves as 1, anything past the store as LINE_MAX
  function automatic int line_len();
    if (width_reg == '0) return 1;
    if (int'(width_reg) > LINE_MAX) return LINE_MAX;
    return int'(width_reg);
  endfunction

  // sort the nine window samples and average the untrimmed middle part
  function automatic logic [PIX_W-1:0] trimmed_mean9(input logic [COL_W-1:0] c0,
                                                     input logic [COL_W-1:0] c1,
                                                     input logic [COL_W-1:0] c2);
    logic [PIX_W-1:0]   v [9];
    logic [PIX_W-1:0]   t;
    logic [3*COL_W-1:0] all;
    int                 a, lo, hi, j, sum;
    all = {c2, c1, c0};
    for (int i = 0; i < 9; i++) v[i] = all[PIX_W*i +: PIX_W];
    for (int i = 1; i < 9; i++) begin
      t = v[i];
      j = i;
      while (j > 0 && v[j-1] > t) begin
        v[j] = v[j-1];
        j--;
      end
      v[j] = t;
    end
    a   = (trim_reg > TRIM_MAX) ? 8 : int'(trim_reg);
    lo  = (a + 1) / 2;
    hi  = 9 - (2 * a + 1) / 4;
    sum = 0;
    for (int i = lo; i < hi; i++) sum += int'(v[i]);
    return PIX_W'(sum / (9 - a));
  endfunction

  function automatic void push_result(input logic [PIX_W-1:0] val, input logic rl,
                                      input logic fl, input logic pinned,
                                      input logic [PIX_W-1:0] pin_val);
    px_result_t r;
    r.filtered   = pinned ? pin_val : val;
    r.row_last   = rl;
    r.frame_last = fl;
    expected_px.push_back(r);
  endfunction

  // advance the model by one accepted transaction
  task automatic filter_pixel(input logic md, input logic [PIX_W-1:0] px,
                              input logic pinned, input logic [PIX_W-1:0] pin_val);
    int               w, c;
    logic             last;
    logic [PIX_W-1:0] top, mid, bot;
    logic [COL_W-1:0] col, p1, p2;
    w = line_len();
    if (md == MODE_DRAIN && !rows_seen) return;   // drain ahead of any row
    c    = (col_pos >= LINE_MAX) ? 0 : col_pos;
    last = (c + 1 >= w);
    top  = upper_q[c];
    mid  = middle_q[c];
    bot  = (md == MODE_DRAIN) ? mid : px;          // drain repeats the bottom row
    if (rows_seen) begin
      col = {bot, mid, top};
      p2  = win_older;
      p1  = win_newer;
      if (c == 0) begin
        // left edge replicated
        p2 = col;
        p1 = col;
      end else begin
        push_result(trimmed_mean9(p2, p1, col), 1'b0, 1'b0, pinned, pin_val);
      end
      // right edge replicated, frame ends on a drain at the last column
      if (last) push_result(trimmed_mean9(p1, col, col), 1'b1, md, pinned, pin_val);
      win_older = p1;
      win_newer = col;
    end
    if (md == MODE_PIXEL) begin
      upper_q[c]  = rows_seen ? mid : px;   // top edge replicated on the first row
      middle_q[c] = px;
    end
    col_pos = last ? 0 : c + 1;
    if (last) rows_seen = (md == MODE_PIXEL);
  endtask

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------
  function automatic logic [PIX_W-1:0] rand_pixel();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PIX_W'($urandom);
  endfunction

  // offer one transaction, with an optional idle burst ahead of it
  task automatic send_px(input logic md, input logic [PIX_W-1:0] px,
                         input logic pinned, input logic [PIX_W-1:0] pin_val);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < tx_idle_pct) gap = $urandom_range(1, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= md;
    pixel    <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (md == MODE_DRAIN && !rows_seen) ignored_drains++;
    else if (counting) rand_items++;
    filter_pixel(md, px, pinned, pin_val);
    if (counting && rand_items >= RAND_ITEMS - QUIET_ITEMS) quiet = 1'b1;
    if (counting && rand_items >= HOLD_AT) hold_req = 1'b1;
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
    if (idx == REG_LINE_WIDTH) width_reg = val;
    else trim_reg = val[TRIM_W-1:0];
  endtask

  // nothing outstanding, and enough quiet cycles for a result-free item to clear
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // finish the current frame: complete a partial first row, then drain
  task automatic close_frame();
    while (rows_seen || col_pos != 0)
      send_px(rows_seen ? MODE_DRAIN : MODE_PIXEL, rand_pixel(), 1'b0, '0);
  endtask

  // one random phase: new settings, then a few frames of random content
  task automatic run_phase(input int p);
    int               r, w, frames, rows;
    bit               big;
    logic [CFG_W-1:0] v;
    logic             md;
    wait_idle();
    big = (p == BIG_PHASE);
    if (big) begin
      write_reg(REG_LINE_WIDTH, '1);   // clamps to the full line store
      write_reg(REG_TRIM_LEVEL, '1);   // clamps to the heaviest trim
    end else begin
      r = $urandom_range(0, 99);
      if (r < 5)       v = '0;
      else if (r < 15) v = CFG_W'(1);
      else if (r < 25) v = CFG_W'(2);
      else if (r < 92) v = CFG_W'($urandom_range(3, 12));
      else             v = CFG_W'($urandom_range(13, 64));
      if ($urandom_range(0, 3) != 0) write_reg(REG_LINE_WIDTH, v);
      // junk in the unused upper bits of a trim write
      v = CFG_W'($urandom);
      v[TRIM_W-1:0] = ($urandom_range(0, 9) == 0) ? TRIM_W'($urandom_range(9, 15))
                                                  : TRIM_W'($urandom_range(0, 8));
      if ($urandom_range(0, 3) != 0) write_reg(REG_TRIM_LEVEL, v);
    end
    tx_idle_pct = 10 * $urandom_range(0, 3);
    rx_idle_pct = 5 * $urandom_range(0, 2);
    counting    = 1'b1;
    if (big) begin
      // no row end inside the clamped width; then pull the width in so the
      // first row closes a few pixels later
      repeat (BIG_PIXELS) send_px(MODE_PIXEL, rand_pixel(), 1'b0, '0);
      wait_idle();
      write_reg(REG_LINE_WIDTH, CFG_W'(BIG_PIXELS + 4));
    end
    w           = line_len();
    frames      = big ? 1 : $urandom_range(1, 3);
    for (int f = 0; f < frames; f++) begin
      if ($urandom_range(0, 99) < 4)
        repeat ($urandom_range(1, 2)) send_px(MODE_DRAIN, rand_pixel(), 1'b0, '0);
      rows = big ? 1 : $urandom_range(1, 4);
      for (int y = 0; y < rows; y++) begin
        for (int x = 0; x < w; x++) begin
          // now and then a drain tick lands in the middle of a later row
          md = (y > 0 && rows_seen && $urandom_range(0, 99) < 3) ? MODE_DRAIN : MODE_PIXEL;
          send_px(md, rand_pixel(), 1'b0, '0);
        end
      end
      // most frames close with a drain row; some run straight on
      if (big || $urandom_range(0, 9) != 0)
        repeat (w) send_px(MODE_DRAIN, rand_pixel(), 1'b0, '0);
    end
    close_frame();
    counting = 1'b0;
  endtask

  // opening script; pinned values follow from the flat frame
  script_row_t script [26] = '{
    '{ROW_CFG,  REG_LINE_WIDTH, CFG_W'(3), MODE_PIXEL, 8'd0,   1'b0, 8'd0},
    '{ROW_CFG,  REG_TRIM_LEVEL, CFG_W'(0), MODE_PIXEL, 8'd0,   1'b0, 8'd0},
    '{ROW_ITEM, REG_LINE_WIDTH, CFG_W'(0), MODE_DRAIN, 8'd0,   1'b0, 8'd0},
    '{ROW_ITEM, REG_LINE_WIDTH, CFG_W'(0), MODE_PIXEL, 8'd255, 1'b0, 8'd0},
    '{ROW_ITEM, REG_LINE_WIDTH, CFG_W'(0), MODE_PIXEL, 8'd255, 1'b0, 8'd0},
    '{ROW_ITEM, REG_LINE_WIDTH, CFG_W'(0), MODE_PIXEL, 8'd255, 1'b0, 8'd0},
    '{ROW_ITEM, REG_LINE_WIDTH, CFG_W'(0), MODE_PIXEL, 8'd255, 1'b1, 8'd255},
    '{ROW_ITEM, REG_LINE_WIDTH, CFG_W'(0), MODE_PIXEL, 8'd255, 1'b1, 8'd255},
    '{ROW_ITEM, REG_LINE_WIDTH, CFG_W'(0), MODE_PIXEL, 8'd255, 1'b1, 8'd255},
    '{ROW_ITEM, REG_LINE_WIDTH, CFG_W'(0), MODE_DRAIN, 8'd0,   1'b1, 8'd255},
    '{ROW_ITEM, REG_LINE_WIDTH, CFG_W'(0), MODE_DRAIN, 8'd0,   1'b1, 8'd255},
    '{ROW_ITEM, REG_LINE_WIDTH, CFG_W'(0), MODE_DRAIN, 8'd0,   1'b1, 8'd255},
    '{ROW_CFG,  REG_TRIM_LEVEL, CFG_W'(8), MODE_PIXEL, 8'd0,   1'b0, 8'd0},
    '{ROW_ITEM, REG_LINE_WIDTH, CFG_W'(0), MODE_PIXEL, 8'd0,   1'b0, 8'd0},
    '{ROW_ITEM, REG_LINE_WIDTH, CFG_W'(0), MODE_PIXEL, 8'd128, 1'b0, 8'd0},
    '{ROW_ITEM, REG_LINE_WIDTH, CFG_W'(0), MODE_PIXEL, 8'd255, 1'b0, 8'd0},
    '{ROW_ITEM, REG_LINE_WIDTH, CFG_W'(0), MODE_PIXEL, 8'd7,   1'b0, 8'd0},
    '{ROW_ITEM, REG_LINE_WIDTH, CFG_W'(0), MODE_PIXEL, 8'd200, 1'b0, 8'd0},
    '{ROW_ITEM, REG_LINE_WIDTH, CFG_W'(0), MODE_PIXEL, 8'd1,   1'b0, 8'd0},
    '{ROW_ITEM, REG_LINE_WIDTH, CFG_W'(0), MODE_DRAIN, 8'd0,   1'b0, 8'd0},
    '{ROW_ITEM, REG_LINE_WIDTH, CFG_W'(0), MODE_DRAIN, 8'd0,   1'b0, 8'd0},
    '{ROW_ITEM, REG_LINE_WIDTH, CFG_W'(0), MODE_DRAIN, 8'd0,   1'b0, 8'd0},
    '{ROW_CFG,  REG_LINE_WIDTH, CFG_W'(0), MODE_PIXEL, 8'd0,   1'b0, 8'd0},
    '{ROW_ITEM, REG_LINE_WIDTH, CFG_W'(0), MODE_PIXEL, 8'd0,   1'b0, 8'd0},
    '{ROW_ITEM, REG_LINE_WIDTH, CFG_W'(0), MODE_PIXEL, 8'd255, 1'b0, 8'd0},
    '{ROW_ITEM, REG_LINE_WIDTH, CFG_W'(0), MODE_DRAIN, 8'd0,   1'b0, 8'd0}
  };

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  initial begin
    int waited;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // opening script: ignored drain, flat frame, heavy trim, single-pixel line
    tx_idle_pct = 20;
    rx_idle_pct = 5;
    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(script[i].idx, script[i].val);
      end else begin
        send_px(script[i].md, script[i].px, script[i].pinned, script[i].pin_val);
      end
    end

    // width shrunk while the third row is under way: column 3 becomes the last
    wait_idle();
    write_reg(REG_LINE_WIDTH, CFG_W'(8));
    write_reg(REG_TRIM_LEVEL, CFG_W'(3));
    repeat (19) send_px(MODE_PIXEL, rand_pixel(), 1'b0, '0);
    wait_idle();
    write_reg(REG_LINE_WIDTH, CFG_W'(4));
    repeat (5) send_px(MODE_PIXEL, rand_pixel(), 1'b0, '0);
    close_frame();

    // random frames until enough transactions have been accepted
    for (int p = 0; rand_items < RAND_ITEMS; p++) run_phase(p);

    // let everything outstanding come back, then a little longer
    in_valid <= 1'b0;
    waited = 0;
    while (expected_px.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_px.size() != 0) begin
      errors += expected_px.size();
      $display("%0t: missing results: expected filtered=%0d (and %0d more), actual none",
               $time, expected_px[0].filtered, expected_px.size() - 1);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d transactions (%0d ignored drain ticks), %0d results, %0d frames.",
             items_sent, ignored_drains, results_seen, frames_seen);
    $display("Line widths 0 to 64 plus an all-ones register, trims 0 to 15, one %0d-cycle hold.",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: compare each transaction with the oldest expectation and
  // pace out_ready (random bursts, one long hold-off, none at the close)
  // --------------------------------------------------------------------------
  px_result_t head_px;
  int         stall_left = 0;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_px.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual filtered=%0d rl=%0b fl=%0b",
                 $time, filtered, row_last, frame_last);
      end else begin
        head_px = expected_px.pop_front();
        results_seen++;
        if (frame_last) frames_seen++;
        if (filtered !== head_px.filtered) begin
          errors++;
          $display("%0t: filtered: expected %0d, actual %0d",
                   $time, head_px.filtered, filtered);
        end
        if (row_last !== head_px.row_last) begin
          errors++;
          $display("%0t: row_last: expected %0b, actual %0b",
                   $time, head_px.row_last, row_last);
        end
        if (frame_last !== head_px.frame_last) begin
          errors++;
          $display("%0t: frame_last: expected %0b, actual %0b",
                   $time, head_px.frame_last, frame_last);
        end
      end
    end

    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      // long hold-off while the sender keeps offering
      hold_done  = 1'b1;
      stall_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < rx_idle_pct) begin
      stall_left = $urandom_range(0, 16);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/atm_pkg.sv
rtl/atm_ram.sv
rtl/atm_tmean.sv
rtl/alpha_trimmed_mean_3x3_top.sv
rtl/atm_check.sv
verif/alpha_trimmed_mean_3x3_top_tb.sv
